// ===== rtl/ils_pkg.sv =====
// Shared types and constants for the indexed list store.
// Used by ils_ctrl, ils_dpath and indexed_list_store_top; depends on nothing.
`default_nettype none

package ils_pkg;

  localparam int CAPACITY = 16;
  localparam int CELL_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ      = 3'd0,
    KIND_OVERWRITE = 3'd1,
    KIND_INSERT    = 3'd2,
    KIND_APPEND    = 3'd3,
    KIND_PREPEND   = 3'd4,
    KIND_DROP_LAST = 3'd5,
    KIND_DROP_FRST = 3'd6,
    KIND_REMOVE    = 3'd7
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [LEN_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         new_length;
  } out_word_t;

  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // apply the captured request and emit the result
  } ils_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_list_store_top.sv =====
// Top level of the indexed list store: a bounded list of 32-bit words.
// Depends on ils_pkg, ils_ctrl and ils_dpath.
`default_nettype none

// Usage: raise start with a request word on in_word while busy is low; the
// word is taken at that clock edge. The list is a row of 16 register cells,
// so insert and remove shift every cell behind the position in one step.
// Each request is first captured into the request register, then applied in
// the cell update, which also loads the result register. The result shows on
// out_word for exactly one cycle with out_valid high, in the cycle in which
// busy falls; the receiver cannot stall it and must take it then.
// A new request may be started in the same cycle the result is shown; busy
// is high while a request executes, so a new one is taken only once it is
// done. After reset the list is empty and no clearing pass is needed.
module indexed_list_store_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ils_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output ils_pkg::out_word_t      out_word
);
  import ils_pkg::*;

  ils_cmd_t cmd;

  // Sequence capture and execute.
  ils_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the cells and length; advance them on execute.
  ils_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== rtl/ils_ctrl.sv =====
// Controller for the indexed list store: two-state one-hot sequencer.
// Depends on ils_pkg; drives the command struct into ils_dpath.
`default_nettype none

module ils_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output ils_pkg::ils_cmd_t      cmd
);
  import ils_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign cmd.load = start && (state_r == ST_IDLE);
  assign cmd.exec = (state_r == ST_EXEC);

endmodule

`default_nettype wire

// ===== rtl/ils_dpath.sv =====
// Datapath for the indexed list store: request register, row of cells,
// length counter and result register. Depends on ils_pkg; driven by ils_ctrl.
`default_nettype none

module ils_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ils_pkg::ils_cmd_t cmd,
  input  wire ils_pkg::in_word_t in_word,
  output logic                   out_valid,
  output ils_pkg::out_word_t     out_word
);
  import ils_pkg::*;

  in_word_t                 req_r;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic signed [DATA_W-1:0] cells_r   [CAPACITY];
  logic signed [DATA_W-1:0] cells_nxt [CAPACITY];
  out_word_t                out_r, out_nxt;
  logic                     out_valid_r;

  logic                     ok;
  logic                     do_write, shift_up, shift_down;
  logic [LEN_W-1:0]         pos;
  logic                     idx_lt_len, idx_le_len, has_room, not_empty;

  assign idx_lt_len = (req_r.index < len_r);
  assign idx_le_len = (req_r.index <= len_r);
  assign has_room   = (len_r < LEN_W'(CAPACITY));
  assign not_empty  = (len_r != '0);

  // Decode the request into a cell action and a length change.
  always_comb begin
    ok         = 1'b0;
    do_write   = 1'b0;
    shift_up   = 1'b0;
    shift_down = 1'b0;
    pos        = req_r.index;
    len_nxt    = len_r;
    unique case (kind_t'(req_r.kind))
      KIND_READ: begin
        ok = idx_lt_len;
      end
      KIND_OVERWRITE: begin
        ok       = idx_lt_len;
        do_write = idx_lt_len;
      end
      KIND_INSERT: begin
        ok       = idx_le_len && has_room;
        do_write = ok;
        shift_up = ok;
        if (ok) len_nxt = len_r + LEN_W'(1);
      end
      KIND_APPEND: begin
        ok       = has_room;
        pos      = len_r;
        do_write = ok;
        if (ok) len_nxt = len_r + LEN_W'(1);
      end
      KIND_PREPEND: begin
        ok       = has_room;
        pos      = '0;
        do_write = ok;
        shift_up = ok;
        if (ok) len_nxt = len_r + LEN_W'(1);
      end
      KIND_DROP_LAST: begin
        ok = not_empty;
        if (ok) len_nxt = len_r - LEN_W'(1);
      end
      KIND_DROP_FRST: begin
        ok         = not_empty;
        pos        = '0;
        shift_down = ok;
        if (ok) len_nxt = len_r - LEN_W'(1);
      end
      KIND_REMOVE: begin
        ok         = idx_lt_len;
        shift_down = ok;
        if (ok) len_nxt = len_r - LEN_W'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Each cell picks its neighbor, the new value, or holds.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (shift_up && (i > 0) && (LEN_W'(i) > pos)) begin
        cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
      end
      if (shift_down && (i < CAPACITY - 1) && (LEN_W'(i) >= pos)) begin
        cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
      if (do_write && (LEN_W'(i) == pos)) begin
        cells_nxt[i] = req_r.value;
      end
    end
  end

  always_comb begin
    out_nxt.ok         = ok;
    out_nxt.new_length = len_nxt;
    out_nxt.read_value = '0;
    if ((kind_t'(req_r.kind) == KIND_READ) && ok) begin
      out_nxt.read_value = cells_r[req_r.index[CELL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_word;
    if (cmd.exec) begin
      out_r <= out_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec) len_r <= len_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire

// ===== tb/sv/indexed_list_store_top_test.sv =====
// Self-checking testbench for indexed_list_store_top: a directed table, then random list traffic.
// Depends on ils_pkg and indexed_list_store_top. An in-bench list model predicts every result word.
module indexed_list_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int RANDOM_WORDS = 1700;
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int IDLE_PCT     = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  indexed_list_store_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List model: a row of cells plus a length, updated once per accepted word.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  int                       cell_count = 0;
  out_word_t                result_q [$];   // expected result words, oldest first
  int                       err_count = 0;
  bit                       growing = 1'b1; // random traffic drifts toward full or empty

  function automatic out_word_t apply_list_op(input in_word_t w);
    out_word_t r;
    int        pos;
    int        ins;
    int        del;
    r   = '0;
    pos = w.index;
    ins = -1;
    del = -1;
    case (kind_t'(w.kind))
      KIND_READ: if (pos < cell_count) begin
        r.read_value = cell_val[pos];
        r.ok         = 1'b1;
      end
      KIND_OVERWRITE: if (pos < cell_count) begin
        cell_val[pos] = w.value;
        r.ok          = 1'b1;
      end
      KIND_INSERT:    if (pos <= cell_count) ins = pos;
      KIND_APPEND:    ins = cell_count;
      KIND_PREPEND:   ins = 0;
      KIND_DROP_LAST: del = cell_count - 1;
      KIND_DROP_FRST: if (cell_count > 0) del = 0;
      KIND_REMOVE:    if (pos < cell_count) del = pos;
      default: ;
    endcase
    // Open a gap behind the insert point; a full list takes nothing.
    if (ins >= 0 && cell_count < CAPACITY) begin
      for (int k = cell_count; k > ins; k--) cell_val[k] = cell_val[k-1];
      cell_val[ins] = w.value;
      cell_count++;
      r.ok = 1'b1;
    end
    // Close the gap left by a removed cell.
    if (del >= 0) begin
      for (int k = del; k < cell_count - 1; k++) cell_val[k] = cell_val[k+1];
      cell_count--;
      r.ok = 1'b1;
    end
    r.new_length = cell_count[LEN_W-1:0];
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed word is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        report_error($sformatf("result word with none expected: ok=%0b rd=%0d len=%0d",
                               out_word.ok, out_word.read_value, out_word.new_length));
      end else begin
        want = result_q.pop_front();
        if (out_word.ok !== want.ok)
          report_error($sformatf("ok got %b want %b", out_word.ok, want.ok));
        if (out_word.read_value !== want.read_value)
          report_error($sformatf("read_value got %0d want %0d",
                                 out_word.read_value, want.read_value));
        if (out_word.new_length !== want.new_length)
          report_error($sformatf("new_length got %0d want %0d",
                                 out_word.new_length, want.new_length));
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one request word, hold it until taken, then record what it should return.
  // A typed expectation replaces the model's answer; the model still advances.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want,
                           input bit may_idle);
    out_word_t predicted;
    if (may_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_list_op(w);
    result_q.push_back(typed ? want : predicted);
  endtask

  // Hold the sender off until every expected result word has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  function automatic in_word_t make_word(input kind_t k, input int idx,
                                         input logic signed [DATA_W-1:0] v);
    in_word_t w;
    w.kind  = k;
    w.index = idx[LEN_W-1:0];
    w.value = v;
    return w;
  endfunction

  // Random request: mostly valid positions, drifting between empty and full so
  // that both boundaries see traffic; a fifth of the indexes land anywhere.
  function automatic in_word_t random_word();
    kind_t                    k;
    int                       roll;
    int                       idx;
    logic signed [DATA_W-1:0] v;
    if (cell_count == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
    if (cell_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
    roll = $urandom_range(99);
    if (roll < 25)
      k = $urandom_range(1) ? KIND_READ : KIND_OVERWRITE;
    else if ((roll < 70) == growing)
      k = kind_t'(KIND_INSERT + $urandom_range(2));
    else
      k = kind_t'(KIND_DROP_LAST + $urandom_range(2));
    idx = ($urandom_range(99) < 80) ? $urandom_range(cell_count) : $urandom_range(CAPACITY);
    case ($urandom_range(19))
      0:       v = 32'sh7FFF_FFFF;
      1:       v = 32'sh8000_0000;
      2:       v = '0;
      3:       v = -1;
      default: v = $urandom;
    endcase
    return make_word(k, idx, v);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    int        reps;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  stim_row_t dir_rows [$];

  task automatic add_row(input kind_t k, input int idx, input logic signed [DATA_W-1:0] v,
                         input int reps, input bit typed, input bit ok,
                         input logic signed [DATA_W-1:0] rd, input int len);
    stim_row_t row;
    row.w               = make_word(k, idx, v);
    row.reps            = reps;
    row.typed           = typed;
    row.want.ok         = ok;
    row.want.read_value = rd;
    row.want.new_length = len[LEN_W-1:0];
    dir_rows.push_back(row);
  endtask

  initial begin
    out_word_t none;
    none = '0;

    // Empty list: every access and removal fails, and a gapped insert too.
    add_row(KIND_READ,      0, 32'sd5,          1, 1, 0, 0, 0);
    add_row(KIND_DROP_LAST, 0, 32'sd0,          1, 1, 0, 0, 0);
    add_row(KIND_DROP_FRST, 0, 32'sd0,          1, 1, 0, 0, 0);
    add_row(KIND_REMOVE,    0, 32'sd0,          1, 1, 0, 0, 0);
    add_row(KIND_OVERWRITE, 0, 32'sd9,          1, 1, 0, 0, 0);
    add_row(KIND_INSERT,    1, 32'sd9,          1, 1, 0, 0, 0);
    // Grow with the value extremes, then insert at the tail and in the middle.
    add_row(KIND_APPEND,    0, 32'sh7FFF_FFFF,  1, 1, 1, 0, 1);
    add_row(KIND_PREPEND,   0, 32'sh8000_0000,  1, 1, 1, 0, 2);
    add_row(KIND_READ,      0, 32'sd0,          1, 1, 1, 32'sh8000_0000, 2);
    add_row(KIND_INSERT,    2, -32'sd1,         1, 1, 1, 0, 3);
    add_row(KIND_INSERT,    1, 32'sh5555_5555,  1, 0, 0, 0, 0);
    // Fill to capacity, then every kind of growth fails.
    add_row(KIND_APPEND,    0, 32'sh0000_A5A5, 12, 0, 0, 0, 0);
    add_row(KIND_APPEND,    0, 32'sd1,          1, 1, 0, 0, 16);
    add_row(KIND_PREPEND,   0, 32'sd1,          1, 1, 0, 0, 16);
    add_row(KIND_INSERT,   16, 32'sd1,          1, 1, 0, 0, 16);
    add_row(KIND_READ,     16, 32'sd0,          1, 1, 0, 0, 16);
    // Work the last cell, both ends, and insert at the head.
    add_row(KIND_READ,     15, 32'sd0,          1, 0, 0, 0, 0);
    add_row(KIND_OVERWRITE,15, 32'shAAAA_AAAA,  1, 0, 0, 0, 0);
    add_row(KIND_REMOVE,   15, 32'sd0,          1, 0, 0, 0, 0);
    add_row(KIND_DROP_FRST, 0, 32'sd0,          1, 0, 0, 0, 0);
    add_row(KIND_DROP_LAST, 0, 32'sd0,          1, 0, 0, 0, 0);
    add_row(KIND_INSERT,    0, 32'sh1234_5678,  1, 0, 0, 0, 0);
    add_row(KIND_READ,      0, 32'sd0,          1, 0, 0, 0, 0);

    // Hold reset, then release it for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++)
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want, 1'b1);
    end

    // Random traffic; back off fully now and then, and run one stretch flat out.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 400 == 0) drain_results();
      send_word(random_word(), 1'b0, none, !(n >= 600 && n < 1000));
    end

    // Let the last results land, then give any stray result word time to show.
    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
